// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check with the reset term masking the property
`define GTM_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("gtm check failed");

// check that must also hold through reset
`define GTM_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("gtm check failed");

`endif

// ----- hw/rtl/gtm_pkg.sv -----
// ----------------------------------------------------------------------------
// gtm_pkg
// shared constants, field widths and types of the glyph template matcher
// ----------------------------------------------------------------------------
`default_nettype none

package gtm_pkg;

   // default store geometry
   localparam int NUM_CODES_DEF  = 128;
   localparam int GLYPH_ROWS_DEF = 16;
   localparam int GLYPH_COLS_DEF = 12;

   // beat field widths
   localparam int CODE_IN_W   = 7;
   localparam int ROW_IN_W    = 4;
   localparam int TMPL_BITS_W = 12;
   localparam int LINE_LEN_W  = 6;
   localparam int GLYPH_W_W   = 8;
   localparam int CHAR_CODE_W = 7;

   // request kinds
   localparam logic REQ_TEMPLATE = 1'b0;
   localparam logic REQ_GLYPH    = 1'b1;

   // '?' reported when nothing matches
   localparam logic [CHAR_CODE_W-1:0] NO_MATCH_CODE = 7'd63;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WUPD,
      ST_SEARCH,
      ST_HOLD
   } gtm_state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/gtm_channel_if.sv -----
// ----------------------------------------------------------------------------
// gtm channel interfaces
// valid/ready request and response channels of the glyph template matcher
// ----------------------------------------------------------------------------
`default_nettype none

interface gtm_req_if
   import gtm_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [CODE_IN_W-1:0]   code;
   logic [ROW_IN_W-1:0]    row_index;
   logic [TMPL_BITS_W-1:0] tmpl_ones;
   logic [TMPL_BITS_W-1:0] tmpl_care;
   logic [LINE_LEN_W-1:0]  line_length;
   logic [TMPL_BITS_W-1:0] glyph_bits;
   logic [GLYPH_W_W-1:0]   glyph_width;
   logic                   glyph_last;

   modport source (
      output valid, req_type, code, row_index, tmpl_ones, tmpl_care,
             line_length, glyph_bits, glyph_width, glyph_last,
      input  ready
   );

   modport sink (
      input  valid, req_type, code, row_index, tmpl_ones, tmpl_care,
             line_length, glyph_bits, glyph_width, glyph_last,
      output ready
   );
endinterface

interface gtm_rsp_if
   import gtm_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   matched;
   logic [CHAR_CODE_W-1:0] char_code;

   modport source (
      output valid, matched, char_code,
      input  ready
   );

   modport sink (
      input  valid, matched, char_code,
      output ready
   );
endinterface

`default_nettype wire

// ----- hw/rtl/glyph_template_matcher_unit.sv -----
// a template row beat in range is written in the update state after idle; a glyph
// row beat that is not the last only fills the glyph buffer. last glyph row: one
// template row compared per cycle through the shared row comparator, a mismatch
// or a zero width skips to the next code at once. after the search the result
// passes the hold state to the result register, waiting there while an earlier
// result beat stalls. reset starts a clearing pass of the template memory and
// the width table, with req ready low meanwhile.
// ----------------------------------------------------------------------------
// glyph_template_matcher_unit
// font template store with a sequential first-match search over all codes
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_template_matcher_unit
   import gtm_pkg::*;
#(
   parameter int NUM_CODES  = NUM_CODES_DEF,
   parameter int GLYPH_ROWS = GLYPH_ROWS_DEF,
   parameter int GLYPH_COLS = GLYPH_COLS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gtm_req_if.sink   req_ch,
   gtm_rsp_if.source rsp_ch
);

   localparam int CODE_W = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;
   localparam int ROW_W  = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
   localparam int DEPTH  = NUM_CODES * GLYPH_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WID_W  = $clog2(GLYPH_COLS + 1);
   localparam int EXT_W  = (GLYPH_COLS > TMPL_BITS_W) ? GLYPH_COLS : TMPL_BITS_W;

   localparam logic [CODE_W-1:0] LAST_CODE = CODE_W'(NUM_CODES - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(GLYPH_ROWS - 1);

   typedef struct packed {
      logic [GLYPH_COLS-1:0] ones;
      logic [GLYPH_COLS-1:0] care;
   } tmpl_entry_type;

   function automatic logic [ADDR_W-1:0] tmpl_addr(input logic [CODE_W-1:0] c,
                                                   input logic [ROW_W-1:0]  r);
      return ADDR_W'(ADDR_W'(c) * ADDR_W'(GLYPH_ROWS) + ADDR_W'(r));
   endfunction

   function automatic logic [GLYPH_COLS-1:0] fit_cols(input logic [TMPL_BITS_W-1:0] v);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(v);
      return ext[GLYPH_COLS-1:0];
   endfunction

   // memories
   tmpl_entry_type        tmem [DEPTH];
   logic [WID_W-1:0]      wmem [NUM_CODES];
   logic [GLYPH_COLS-1:0] gbuf [GLYPH_ROWS];

   tmpl_entry_type        tmem_rd_ff;
   logic [WID_W-1:0]      wmem_rd_ff;
   logic [GLYPH_COLS-1:0] gbuf_rd_ff;

   // control state
   gtm_state_type     state_ff, state_in;
   logic [CODE_W-1:0] iss_code_ff, iss_code_in;
   logic [ROW_W-1:0]  iss_row_ff, iss_row_in;
   logic              iss_end_ff, iss_end_in;
   logic              p1_valid_ff, p1_valid_in;
   logic [CODE_W-1:0] p1_code_ff, p1_code_in;
   logic              p1_last_ff, p1_last_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ADDR_W-1:0]      wr_addr_ff;
   logic [CODE_W-1:0]      wr_code_ff;
   tmpl_entry_type         wr_entry_ff;
   logic [WID_W-1:0]       wr_width_ff;
   logic [GLYPH_W_W-1:0]   gw_ff;
   logic                   res_matched_ff, res_matched_in;
   logic [CHAR_CODE_W-1:0] res_code_ff, res_code_in;
   logic                   rsp_matched_ff;
   logic [CHAR_CODE_W-1:0] rsp_code_ff;

   // combinational control
   logic                  accept;
   logic                  code_ok, row_ok;
   logic                  wr_capture, gw_capture, out_load;
   logic                  jump, mismatch;
   logic [GLYPH_COLS-1:0] col_mask, diff;
   logic [CODE_W-1:0]     sel_code, nxt_code;
   logic [ROW_W-1:0]      sel_row, nxt_row;
   logic                  sel_end;
   logic [ADDR_W-1:0]     sel_addr;
   logic                  tmem_we, wmem_we, gbuf_we;
   logic [ADDR_W-1:0]     tmem_waddr;
   tmpl_entry_type        tmem_wdata;
   logic [CODE_W-1:0]     wmem_waddr, wmem_raddr;
   logic [WID_W-1:0]      wmem_wdata;
   logic [WID_W-1:0]      sat_width;

   assign accept  = req_ch.valid && req_ch.ready;
   assign code_ok = int'(req_ch.code) < NUM_CODES;
   assign row_ok  = int'(req_ch.row_index) < GLYPH_ROWS;
   assign sat_width = (int'(req_ch.line_length) > GLYPH_COLS) ?
                      WID_W'(GLYPH_COLS) : WID_W'(req_ch.line_length);

   // row comparator: columns below min(template width, glyph width)
   always_comb begin
      for (int i = 0; i < GLYPH_COLS; i++) begin
         col_mask[i] = (WID_W'(i) < wmem_rd_ff) && (GLYPH_W_W'(i) < gw_ff);
      end
      diff     = (tmem_rd_ff.ones ^ gbuf_rd_ff) & tmem_rd_ff.care & col_mask;
      mismatch = (wmem_rd_ff == '0) || (|diff);
   end

   // pointer to issue: a failing template jumps straight to the next code
   always_comb begin
      jump     = (state_ff == ST_SEARCH) && p1_valid_ff && mismatch &&
                 (p1_code_ff != LAST_CODE);
      sel_code = jump ? CODE_W'(p1_code_ff + 1'b1) : iss_code_ff;
      sel_row  = jump ? '0 : iss_row_ff;
      sel_end  = (sel_row == LAST_ROW) && (sel_code == LAST_CODE);
      nxt_row  = (sel_row == LAST_ROW) ? '0 : ROW_W'(sel_row + 1'b1);
      nxt_code = (sel_row == LAST_ROW) ? CODE_W'(sel_code + 1'b1) : sel_code;
      sel_addr = tmpl_addr(sel_code, sel_row);
   end

   always_comb begin
      state_in       = state_ff;
      iss_code_in    = iss_code_ff;
      iss_row_in     = iss_row_ff;
      iss_end_in     = iss_end_ff;
      p1_valid_in    = 1'b0;
      p1_code_in     = p1_code_ff;
      p1_last_in     = p1_last_ff;
      res_matched_in = res_matched_ff;
      res_code_in    = res_code_ff;
      req_ch.ready   = 1'b0;
      wr_capture     = 1'b0;
      gw_capture     = 1'b0;
      out_load       = 1'b0;
      tmem_we        = 1'b0;
      tmem_waddr     = sel_addr;
      tmem_wdata     = '0;
      wmem_we        = 1'b0;
      wmem_waddr     = sel_code;
      wmem_wdata     = '0;
      wmem_raddr     = sel_code;
      gbuf_we        = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            tmem_we     = 1'b1;
            wmem_we     = 1'b1;
            iss_code_in = nxt_code;
            iss_row_in  = nxt_row;
            if (sel_end) begin
               iss_code_in = '0;
               iss_row_in  = '0;
               state_in    = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_ch.ready = 1'b1;
            // old width read here for the read-modify-write of a template beat
            wmem_raddr   = CODE_W'(req_ch.code);
            if (accept) begin
               if (req_ch.req_type == REQ_TEMPLATE) begin
                  if (code_ok && row_ok) begin
                     wr_capture = 1'b1;
                     state_in   = ST_WUPD;
                  end
               end else begin
                  gbuf_we = row_ok;
                  if (req_ch.glyph_last) begin
                     gw_capture  = 1'b1;
                     iss_code_in = '0;
                     iss_row_in  = '0;
                     iss_end_in  = 1'b0;
                     state_in    = ST_SEARCH;
                  end
               end
            end
         end

         ST_WUPD: begin
            tmem_we    = 1'b1;
            tmem_waddr = wr_addr_ff;
            tmem_wdata = wr_entry_ff;
            wmem_waddr = wr_code_ff;
            wmem_wdata = wr_width_ff;
            wmem_we    = wr_width_ff > wmem_rd_ff;
            state_in   = ST_IDLE;
         end

         ST_SEARCH: begin
            if (p1_valid_ff && !mismatch && p1_last_ff) begin
               res_matched_in = 1'b1;
               res_code_in    = CHAR_CODE_W'(p1_code_ff);
               state_in       = ST_HOLD;
            end else if (p1_valid_ff && mismatch && (p1_code_ff == LAST_CODE)) begin
               res_matched_in = 1'b0;
               res_code_in    = NO_MATCH_CODE;
               state_in       = ST_HOLD;
            end else if (jump || !iss_end_ff) begin
               p1_valid_in = 1'b1;
               p1_code_in  = sel_code;
               p1_last_in  = sel_row == LAST_ROW;
               iss_code_in = nxt_code;
               iss_row_in  = nxt_row;
               iss_end_in  = sel_end;
            end
         end

         ST_HOLD: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         iss_code_ff  <= '0;
         iss_row_ff   <= '0;
         iss_end_ff   <= 1'b0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_code_ff  <= iss_code_in;
         iss_row_ff   <= iss_row_in;
         iss_end_ff   <= iss_end_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_code_ff     <= p1_code_in;
      p1_last_ff     <= p1_last_in;
      res_matched_ff <= res_matched_in;
      res_code_ff    <= res_code_in;
      if (wr_capture) begin
         wr_addr_ff       <= tmpl_addr(CODE_W'(req_ch.code), ROW_W'(req_ch.row_index));
         wr_code_ff       <= CODE_W'(req_ch.code);
         wr_entry_ff.ones <= fit_cols(req_ch.tmpl_ones);
         wr_entry_ff.care <= fit_cols(req_ch.tmpl_care);
         wr_width_ff      <= sat_width;
      end
      if (gw_capture) begin
         gw_ff <= req_ch.glyph_width;
      end
      if (out_load) begin
         rsp_matched_ff <= res_matched_ff;
         rsp_code_ff    <= res_code_ff;
      end
   end

   // template store, width table and glyph buffer
   always_ff @(posedge clock) begin
      if (tmem_we) begin
         tmem[tmem_waddr] <= tmem_wdata;
      end
      tmem_rd_ff <= tmem[sel_addr];
   end

   always_ff @(posedge clock) begin
      if (wmem_we) begin
         wmem[wmem_waddr] <= wmem_wdata;
      end
      wmem_rd_ff <= wmem[wmem_raddr];
   end

   always_ff @(posedge clock) begin
      if (gbuf_we) begin
         gbuf[ROW_W'(req_ch.row_index)] <= fit_cols(req_ch.glyph_bits);
      end
      gbuf_rd_ff <= gbuf[sel_row];
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.matched   = rsp_matched_ff;
   assign rsp_ch.char_code = rsp_code_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/gtm_checker.sv -----
// ----------------------------------------------------------------------------
// gtm_checker
// port-level checks of the glyph template matcher, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gtm_checker
   import gtm_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   req_type,
   input logic                   glyph_last,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic                   matched,
   input logic [CHAR_CODE_W-1:0] char_code
);

   // clearing pass follows reset, nothing taken or shown
   `GTM_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !req_ready && !rsp_valid)

   // a last glyph row starts the search, so the next beat waits
   `GTM_ASSERT(a_search_busy, clock, reset,
      req_valid && req_ready && (req_type == REQ_GLYPH) && glyph_last |=> !req_ready)

   // no-match result always carries '?'
   `GTM_ASSERT(a_nomatch_code, clock, reset,
      rsp_valid && !matched |-> char_code == NO_MATCH_CODE)

   // a stalled result beat holds
   `GTM_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(matched) && $stable(char_code))

endmodule

bind glyph_template_matcher_unit gtm_checker u_gtm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_type   (req_ch.req_type),
   .glyph_last (req_ch.glyph_last),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .matched    (rsp_ch.matched),
   .char_code  (rsp_ch.char_code)
);

`default_nettype wire

// ----- verif/gtm_match_checker.sv -----
// ----------------------------------------------------------------------------
// gtm_match_checker
// watches both channels of the glyph template matcher, keeps its own copy of
// the font store and glyph buffer, predicts each search and checks the results
// ----------------------------------------------------------------------------
`default_nettype none

module gtm_match_checker
   import gtm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   gtm_req_if   req_mon,
   gtm_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count
);

   localparam int STORE_ROWS = NUM_CODES_DEF * GLYPH_ROWS_DEF;

   typedef struct packed {
      logic                   matched;
      logic [CHAR_CODE_W-1:0] char_code;
   } match_result_type;

   logic [TMPL_BITS_W-1:0] font_ones  [STORE_ROWS];
   logic [TMPL_BITS_W-1:0] font_care  [STORE_ROWS];
   logic [3:0]             font_width [NUM_CODES_DEF];
   logic [TMPL_BITS_W-1:0] glyph_rows [GLYPH_ROWS_DEF];

   match_result_type search_results_q[$];
   int               errs;

   // first template, lowest code first, that agrees on every cared-for cell below both widths
   function automatic match_result_type search_font(input logic [GLYPH_W_W-1:0] gw);
      match_result_type       res;
      int                     n;
      logic [TMPL_BITS_W-1:0] colmask;
      bit                     hit;
      res.matched = 1'b0;
      res.char_code = NO_MATCH_CODE;
      for (int c = 0; c < NUM_CODES_DEF; c++) begin
         if (font_width[c] != 0) begin
            n = (int'(font_width[c]) < int'(gw)) ? int'(font_width[c]) : int'(gw);
            colmask = (n >= GLYPH_COLS_DEF) ? '1 : TMPL_BITS_W'((1 << n) - 1);
            hit = 1'b1;
            for (int r = 0; r < GLYPH_ROWS_DEF; r++) begin
               if (((font_ones[c*GLYPH_ROWS_DEF+r] ^ glyph_rows[r])
                    & font_care[c*GLYPH_ROWS_DEF+r] & colmask) != 0)
                  hit = 1'b0;
            end
            if (hit) begin
               res.matched = 1'b1;
               res.char_code = CHAR_CODE_W'(c);
               return res;
            end
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what, input int want_v, input int got_v);
      errs++;
      if (errs <= 10)
         $display("gtm check: %s expected %0d got %0d at %0t", what, want_v, got_v, $time);
   endtask

   always @(posedge clock) begin : watch
      match_result_type want;
      int               idx;
      int               w;
      if (reset) begin
         for (int i = 0; i < STORE_ROWS; i++) begin
            font_ones[i] = '0;
            font_care[i] = '0;
         end
         for (int c = 0; c < NUM_CODES_DEF; c++)
            font_width[c] = '0;
         for (int r = 0; r < GLYPH_ROWS_DEF; r++)
            glyph_rows[r] = '0;
         search_results_q.delete();
      end else begin
         // results first: a result beat always belongs to an earlier glyph
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (search_results_q.size() == 0) begin
               note_mismatch("result with nothing pending, char_code", -1,
                             int'(rsp_mon.char_code));
            end else begin
               want = search_results_q.pop_front();
               if (rsp_mon.matched !== want.matched)
                  note_mismatch("matched", int'(want.matched), int'(rsp_mon.matched));
               if (rsp_mon.char_code !== want.char_code)
                  note_mismatch("char_code", int'(want.char_code), int'(rsp_mon.char_code));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.req_type == REQ_TEMPLATE) begin
               idx = int'(req_mon.code) * GLYPH_ROWS_DEF + int'(req_mon.row_index);
               font_ones[idx] = req_mon.tmpl_ones;
               font_care[idx] = req_mon.tmpl_care;
               // width only grows, saturating at the column count
               w = (int'(req_mon.line_length) > GLYPH_COLS_DEF) ? GLYPH_COLS_DEF
                                                               : int'(req_mon.line_length);
               if (w > int'(font_width[req_mon.code]))
                  font_width[req_mon.code] = 4'(w);
            end else begin
               glyph_rows[req_mon.row_index] = req_mon.glyph_bits;
               if (req_mon.glyph_last)
                  search_results_q.push_back(search_font(req_mon.glyph_width));
            end
         end
      end
      mismatch_count <= errs;
      pending_count <= search_results_q.size();
   end

endmodule

`default_nettype wire

// ----- verif/glyph_template_matcher_unit_tb.sv -----
// ----------------------------------------------------------------------------
// glyph_template_matcher_unit_tb
// fills the font store and sends glyphs, most of them built from stored
// templates with random don't-care cells, under random stalls on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_template_matcher_unit_tb;
   import gtm_pkg::*;

   localparam int ITEM_TARGET  = 1000;
   localparam int QUIET_LIMIT  = 20000;
   localparam int TAIL_CYCLES  = 64;

   typedef struct packed {
      logic                   req_type;
      logic [CODE_IN_W-1:0]   code;
      logic [ROW_IN_W-1:0]    row_index;
      logic [TMPL_BITS_W-1:0] tmpl_ones;
      logic [TMPL_BITS_W-1:0] tmpl_care;
      logic [LINE_LEN_W-1:0]  line_length;
      logic [TMPL_BITS_W-1:0] glyph_bits;
      logic [GLYPH_W_W-1:0]   glyph_width;
      logic                   glyph_last;
   } req_beat_type;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   pending_count;

   gtm_req_if req_ch ();
   gtm_rsp_if rsp_ch ();

   glyph_template_matcher_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   gtm_match_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // what has been written, used only to build glyphs that ought to match
   logic [TMPL_BITS_W-1:0] shadow_ones  [NUM_CODES_DEF][GLYPH_ROWS_DEF];
   logic [TMPL_BITS_W-1:0] shadow_care  [NUM_CODES_DEF][GLYPH_ROWS_DEF];
   int                     shadow_width [NUM_CODES_DEF];
   int                     live_codes[$];

   int items_sent;
   int searches_sent;
   bit calm;
   int stall_left;
   int quiet_cycles;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_glyph_width();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return 0;
      if (r < 20)
         return $urandom_range(13, 255);
      return $urandom_range(1, GLYPH_COLS_DEF);
   endfunction

   function automatic req_beat_type random_beat();
      logic [63:0]  raw;
      req_beat_type b;
      raw = {$urandom, $urandom};
      b = raw[$bits(req_beat_type)-1:0];
      return b;
   endfunction

   task automatic send_beat(input req_beat_type b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.req_type    <= b.req_type;
      req_ch.code        <= b.code;
      req_ch.row_index   <= b.row_index;
      req_ch.tmpl_ones   <= b.tmpl_ones;
      req_ch.tmpl_care   <= b.tmpl_care;
      req_ch.line_length <= b.line_length;
      req_ch.glyph_bits  <= b.glyph_bits;
      req_ch.glyph_width <= b.glyph_width;
      req_ch.glyph_last  <= b.glyph_last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic write_template_row(input int c, input int r,
                                     input logic [TMPL_BITS_W-1:0] ones,
                                     input logic [TMPL_BITS_W-1:0] care, input int len);
      req_beat_type b;
      int           w;
      b = random_beat();
      b.req_type = REQ_TEMPLATE;
      b.code = CODE_IN_W'(c);
      b.row_index = ROW_IN_W'(r);
      b.tmpl_ones = ones;
      b.tmpl_care = care;
      b.line_length = LINE_LEN_W'(len);
      shadow_ones[c][r] = ones;
      shadow_care[c][r] = care;
      w = (len > GLYPH_COLS_DEF) ? GLYPH_COLS_DEF : len;
      if (w > 0 && shadow_width[c] == 0)
         live_codes.push_back(c);
      if (w > shadow_width[c])
         shadow_width[c] = w;
      send_beat(b);
   endtask

   task automatic write_glyph_row(input int r, input logic [TMPL_BITS_W-1:0] bits,
                                  input int gw, input bit last);
      req_beat_type b;
      b = random_beat();
      b.req_type = REQ_GLYPH;
      b.row_index = ROW_IN_W'(r);
      b.glyph_bits = bits;
      b.glyph_width = GLYPH_W_W'(gw);
      b.glyph_last = last;
      if (last)
         searches_sent++;
      send_beat(b);
   endtask

   // result side: random stalls, mostly short, now and then long
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!calm && $urandom_range(0, 99) < 30)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(1, 3);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int                     pool[16];
      int                     order[16];
      int                     c;
      int                     r;
      int                     k;
      int                     t;
      int                     n;
      int                     gw;
      int                     len;
      int                     flip_at;
      logic [TMPL_BITS_W-1:0] bits;
      logic [TMPL_BITS_W-1:0] care;

      reset <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.req_type    <= REQ_TEMPLATE;
      req_ch.code        <= '0;
      req_ch.row_index   <= '0;
      req_ch.tmpl_ones   <= '0;
      req_ch.tmpl_care   <= '0;
      req_ch.line_length <= '0;
      req_ch.glyph_bits  <= '0;
      req_ch.glyph_width <= '0;
      req_ch.glyph_last  <= 1'b0;
      items_sent = 0;
      searches_sent = 0;
      calm = 1'b0;
      for (int i = 0; i < NUM_CODES_DEF; i++) begin
         shadow_width[i] = 0;
         for (int j = 0; j < GLYPH_ROWS_DEF; j++) begin
            shadow_ones[i][j] = '0;
            shadow_care[i][j] = '0;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty store: a full glyph must come back as no match
      for (int i = 0; i < GLYPH_ROWS_DEF; i++)
         write_glyph_row(i, (i == 0) ? '1 : (i == 1) ? '0 : TMPL_BITS_W'($urandom),
                         GLYPH_COLS_DEF, i == GLYPH_ROWS_DEF - 1);
      // zero line length leaves the template skipped
      write_template_row(NUM_CODES_DEF - 1, 3, '1, '1, 0);
      // overlong line saturates the width
      write_template_row(0, 0, '0, '1, 63);
      // glyph width zero: lowest live code wins
      write_glyph_row(15, TMPL_BITS_W'($urandom), 0, 1'b1);
      // wide glyph, nothing agrees
      write_glyph_row(0, '1, 255, 1'b1);
      // width kept at its maximum by a later shorter line
      write_template_row(5, 0, '1, '1, 1);
      write_template_row(5, 0, '1, '1, 0);
      write_glyph_row(0, 12'h001, 255, 1'b1);

      for (int i = 0; i < 16; i++)
         pool[i] = $urandom_range(0, NUM_CODES_DEF - 1);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 19) == 0)
            calm = !calm;
         t = $urandom_range(0, 99);
         if (t < 40) begin
            c = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 15)]
                                           : $urandom_range(0, NUM_CODES_DEF - 1);
            k = $urandom_range(0, 9);
            len = (k == 0) ? 0 : (k == 1) ? $urandom_range(13, 63)
                                          : $urandom_range(1, GLYPH_COLS_DEF);
            n = ($urandom_range(0, 9) < 6) ? GLYPH_ROWS_DEF : $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
               r = (n == GLYPH_ROWS_DEF) ? i : $urandom_range(0, GLYPH_ROWS_DEF - 1);
               case ($urandom_range(0, 3))
                  0: care = '1;
                  1: care = TMPL_BITS_W'($urandom);
                  2: care = TMPL_BITS_W'($urandom & $urandom);
                  default: care = TMPL_BITS_W'($urandom | $urandom);
               endcase
               write_template_row(c, r, TMPL_BITS_W'($urandom), care, len);
            end
         end else if (t < 85 && live_codes.size() > 0) begin
            // glyph drawn from a stored template, sometimes spoilt by one pixel
            c = live_codes[$urandom_range(0, live_codes.size() - 1)];
            gw = pick_glyph_width();
            flip_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : -1;
            for (int i = 0; i < GLYPH_ROWS_DEF; i++)
               order[i] = i;
            if ($urandom_range(0, 9) < 3) begin
               for (int i = GLYPH_ROWS_DEF - 1; i > 0; i--) begin
                  k = $urandom_range(0, i);
                  r = order[i];
                  order[i] = order[k];
                  order[k] = r;
               end
            end
            for (int i = 0; i < GLYPH_ROWS_DEF; i++) begin
               r = order[i];
               bits = (shadow_ones[c][r] & shadow_care[c][r])
                      | (TMPL_BITS_W'($urandom) & ~shadow_care[c][r]);
               if (i == flip_at)
                  bits ^= TMPL_BITS_W'(1 << $urandom_range(0, GLYPH_COLS_DEF - 1));
               write_glyph_row(r, bits, gw, i == GLYPH_ROWS_DEF - 1);
            end
         end else begin
            // partial glyph of random rows
            n = $urandom_range(1, GLYPH_ROWS_DEF);
            gw = pick_glyph_width();
            for (int i = 0; i < n; i++)
               write_glyph_row($urandom_range(0, GLYPH_ROWS_DEF - 1),
                               TMPL_BITS_W'($urandom), gw, i == n - 1);
         end
      end
      req_ch.valid <= 1'b0;
      calm = 1'b0;

      repeat (2) @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/gtm_pkg.sv
hw/rtl/gtm_channel_if.sv
hw/rtl/glyph_template_matcher_unit.sv
hw/rtl/gtm_checker.sv
verif/gtm_match_checker.sv
verif/glyph_template_matcher_unit_tb.sv
